// ===== sv/langevin_particle_step_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the Langevin particle step
// Shorthand for clocked implication checks.
// ----------------------------------------------------------------------------
`ifndef LANGEVIN_PARTICLE_STEP_MACROS_SVH
`define LANGEVIN_PARTICLE_STEP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define LPS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the following cycle
`define LPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/lps_pkg.sv =====
// ----------------------------------------------------------------------------
// lps_pkg
// Widths, register indexes and helpers shared by the particle step blocks.
// ----------------------------------------------------------------------------
package lps_pkg;

  localparam int unsigned COMP_W = 21;
  localparam int unsigned VEC_W  = 63;
  localparam int unsigned SUM_W  = 42;  // sum of three squared components
  localparam int unsigned ROOT_W = 31;  // isqrt of sum * 2^20
  localparam int unsigned QUO_W  = 12;  // quotient magnitude
  localparam int unsigned NRM_W  = 13;  // signed normalized component

  typedef logic signed [COMP_W-1:0] comp_t;
  typedef logic signed [NRM_W-1:0]  nrm_t;
  typedef logic [VEC_W-1:0]         vec_t;

  localparam logic [3:0] REG_STEP_SIZE  = 4'd0;
  localparam logic [3:0] REG_NOISE_GAIN = 4'd1;
  localparam logic [3:0] REG_MIN_CORNER = 4'd2;
  localparam logic [3:0] REG_MAX_CORNER = 4'd3;

  function automatic comp_t vec_comp(vec_t v, int unsigned k);
    return comp_t'(v[k*COMP_W +: COMP_W]);
  endfunction

endpackage

// ===== sv/lps_norm.sv =====
// ----------------------------------------------------------------------------
// lps_norm
// Pipelined direction normalizer: squares, one root bit per stage, then one
// quotient bit per stage for the three components. Side data rides along.
// ----------------------------------------------------------------------------
module lps_norm #(
  parameter int unsigned SIDE_W = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  lps_pkg::vec_t     dir_i,
  input  logic [SIDE_W-1:0] side_i,
  output logic              valid_o,
  output lps_pkg::nrm_t     n_o [3],
  output logic [SIDE_W-1:0] side_o
);
  import lps_pkg::*;

  localparam int unsigned SQ_ST  = ROOT_W;
  localparam int unsigned DIV_ST = QUO_W;

  // square stage
  logic              sq_vld_q;
  logic [SUM_W-1:0]  sq_q   [3];
  logic [COMP_W-1:0] sq_mag_q [3];
  logic              sq_neg_q [3];
  logic [SIDE_W-1:0] sq_side_q;

  // root stages
  logic              rt_vld_q  [SQ_ST+1];
  logic [SUM_W-1:0]  rt_s_q    [SQ_ST+1];
  logic [ROOT_W+1:0] rt_rem_q  [SQ_ST+1];
  logic [ROOT_W-1:0] rt_root_q [SQ_ST+1];
  logic [COMP_W-1:0] rt_mag_q  [SQ_ST+1][3];
  logic              rt_neg_q  [SQ_ST+1][3];
  logic [SIDE_W-1:0] rt_side_q [SQ_ST+1];
  logic [ROOT_W+1:0] rt_rem_d  [SQ_ST];
  logic [ROOT_W-1:0] rt_root_d [SQ_ST];
  logic [ROOT_W+3:0] rt_x      [SQ_ST];
  logic [ROOT_W+3:0] rt_t      [SQ_ST];
  logic [SUM_W+19:0] rt_big    [SQ_ST];

  // divide stages
  logic              dv_vld_q  [DIV_ST+1];
  logic [ROOT_W-1:0] dv_r_q    [DIV_ST+1];
  logic [ROOT_W-1:0] dv_rem_q  [DIV_ST+1][3];
  logic [QUO_W-1:0]  dv_quo_q  [DIV_ST+1][3];
  logic              dv_neg_q  [DIV_ST+1][3];
  logic              dv_zero_q [DIV_ST+1];
  logic [SIDE_W-1:0] dv_side_q [DIV_ST+1];
  logic [ROOT_W-1:0] dv_rem_d  [DIV_ST][3];
  logic              dv_ge     [DIV_ST][3];
  logic [ROOT_W:0]   dv_x      [DIV_ST][3];

  comp_t             d_c   [3];
  logic [SUM_W-1:0]  s_sum;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_c[i] = vec_comp(dir_i, i);
    end
    s_sum = sq_q[0] + sq_q[1] + sq_q[2];
  end

  // one root bit per stage, digit-by-digit
  always_comb begin
    for (int j = 0; j < SQ_ST; j++) begin
      rt_big[j] = {rt_s_q[j], 20'b0};
      rt_x[j]   = {rt_rem_q[j], rt_big[j][2*(SQ_ST-1-j)+1 -: 2]};
      rt_t[j]   = {2'b00, rt_root_q[j], 2'b01};
      if (rt_x[j] >= rt_t[j]) begin
        rt_rem_d[j]  = (ROOT_W+2)'(rt_x[j] - rt_t[j]);
        rt_root_d[j] = {rt_root_q[j][ROOT_W-2:0], 1'b1};
      end else begin
        rt_rem_d[j]  = (ROOT_W+2)'(rt_x[j]);
        rt_root_d[j] = {rt_root_q[j][ROOT_W-2:0], 1'b0};
      end
    end
  end

  // one quotient bit per stage; partial remainder stays below r whenever r is nonzero
  always_comb begin
    for (int j = 0; j < DIV_ST; j++) begin
      for (int i = 0; i < 3; i++) begin
        dv_x[j][i]  = {dv_rem_q[j][i], 1'b0};
        dv_ge[j][i] = dv_x[j][i] >= {1'b0, dv_r_q[j]};
        dv_rem_d[j][i] = dv_ge[j][i] ? ROOT_W'(dv_x[j][i] - {1'b0, dv_r_q[j]})
                                     : ROOT_W'(dv_x[j][i]);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_vld_q <= 1'b0;
      for (int j = 0; j <= SQ_ST; j++) rt_vld_q[j] <= 1'b0;
      for (int j = 0; j <= DIV_ST; j++) dv_vld_q[j] <= 1'b0;
    end else if (en_i) begin
      sq_vld_q    <= valid_i;
      rt_vld_q[0] <= sq_vld_q;
      for (int j = 0; j < SQ_ST; j++) rt_vld_q[j+1] <= rt_vld_q[j];
      dv_vld_q[0] <= rt_vld_q[SQ_ST];
      for (int j = 0; j < DIV_ST; j++) dv_vld_q[j+1] <= dv_vld_q[j];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq_q[i]     <= SUM_W'(d_c[i]) * SUM_W'(d_c[i]);
        sq_mag_q[i] <= d_c[i][COMP_W-1] ? COMP_W'(-d_c[i]) : COMP_W'(d_c[i]);
        sq_neg_q[i] <= d_c[i][COMP_W-1];
      end
      sq_side_q <= side_i;

      rt_s_q[0]    <= s_sum;
      rt_rem_q[0]  <= '0;
      rt_root_q[0] <= '0;
      rt_mag_q[0]  <= sq_mag_q;
      rt_neg_q[0]  <= sq_neg_q;
      rt_side_q[0] <= sq_side_q;
      for (int j = 0; j < SQ_ST; j++) begin
        rt_s_q[j+1]    <= rt_s_q[j];
        rt_rem_q[j+1]  <= rt_rem_d[j];
        rt_root_q[j+1] <= rt_root_d[j];
        rt_mag_q[j+1]  <= rt_mag_q[j];
        rt_neg_q[j+1]  <= rt_neg_q[j];
        rt_side_q[j+1] <= rt_side_q[j];
      end

      dv_r_q[0]    <= rt_root_q[SQ_ST];
      dv_zero_q[0] <= (rt_s_q[SQ_ST] == '0);
      dv_side_q[0] <= rt_side_q[SQ_ST];
      for (int i = 0; i < 3; i++) begin
        dv_rem_q[0][i] <= ROOT_W'({rt_mag_q[SQ_ST][i], 9'b0});
        dv_quo_q[0][i] <= '0;
        dv_neg_q[0][i] <= rt_neg_q[SQ_ST][i];
      end
      for (int j = 0; j < DIV_ST; j++) begin
        dv_r_q[j+1]    <= dv_r_q[j];
        dv_zero_q[j+1] <= dv_zero_q[j];
        dv_side_q[j+1] <= dv_side_q[j];
        for (int i = 0; i < 3; i++) begin
          dv_rem_q[j+1][i] <= dv_rem_d[j][i];
          dv_quo_q[j+1][i] <= {dv_quo_q[j][i][QUO_W-2:0], dv_ge[j][i]};
          dv_neg_q[j+1][i] <= dv_neg_q[j][i];
        end
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_q[DIV_ST]) begin
        n_o[i] = '0;
      end else if (dv_neg_q[DIV_ST][i]) begin
        n_o[i] = -nrm_t'({1'b0, dv_quo_q[DIV_ST][i]});
      end else begin
        n_o[i] = nrm_t'({1'b0, dv_quo_q[DIV_ST][i]});
      end
    end
  end

  assign valid_o = dv_vld_q[DIV_ST];
  assign side_o  = dv_side_q[DIV_ST];

endmodule

// ===== sv/langevin_particle_step.sv =====
// ----------------------------------------------------------------------------
// langevin_particle_step
// Advances one particle per transfer by its velocity and a normalized,
// stress-shaped noise kick, with a box test that reseeds escaped particles.
// ----------------------------------------------------------------------------
// One particle enters per clock while the pipe advances. The normalizer
// spends one stage per bit of the 31-bit square root and one per bit of the
// 12-bit quotient. The whole pipe advances whenever the output register is
// empty or being taken, so the sustained rate is one item per cycle.
// Configuration is taken at any time (cfg_ready_o is always high) and must
// only change while the pipe is empty.
module langevin_particle_step (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  // position_in[62:0], velocity[125:63], stress_diag[188:126],
  // stress_off[251:189], random_dir[314:252], entrance_pos[377:315]
  input  logic [383:0] s_axis_tdata_i,
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  // position_out[62:0]
  output logic [63:0]  m_axis_tdata_o,
  // reseeded[0]
  output logic         m_axis_tuser_o,
  input  logic         cfg_valid_i,
  output logic         cfg_ready_o,
  input  logic [3:0]   cfg_index_i,
  input  logic [63:0]  cfg_data_i
);
  import lps_pkg::*;
  `include "langevin_particle_step_macros.svh"

  localparam int unsigned SIDE_W = 5 * VEC_W;
  localparam int unsigned PR_W   = COMP_W + NRM_W;  // 34
  localparam int unsigned V_W    = PR_W + 2;        // 36
  localparam int unsigned VG_W   = V_W + 17;        // 53
  localparam int unsigned A_W    = 38;
  localparam int unsigned DP_W   = A_W + 17;        // 55
  localparam int unsigned P_W    = 34;
  localparam logic signed [P_W-1:0]  P_MIN = -(P_W'(1) <<< (COMP_W-1));
  localparam logic signed [P_W-1:0]  P_MAX = (P_W'(1) <<< (COMP_W-1)) - 1;
  localparam logic signed [DP_W-1:0] HALF  = DP_W'(1) <<< 22;

  logic        [15:0] step_q, gain_q;
  vec_t               min_q, max_q;

  logic               en;
  logic               n_vld;
  nrm_t               n_c [3];
  logic [SIDE_W-1:0]  n_side;
  vec_t               sd_c, so_c;
  comp_t              m_c [3][3];

  logic                   vld_q [5];
  logic signed [PR_W-1:0] pr1_q [3][3];
  logic signed [V_W-1:0]  v2_q  [3];
  logic signed [VG_W-1:0] vg3_q [3];
  logic signed [A_W-1:0]  a4_q  [3];
  logic signed [DP_W-1:0] dp5_q [3];
  vec_t                   pos_q [5];
  vec_t                   vel_q [5];
  vec_t                   ent_q [5];

  logic                   out_vld_q, reseed_q;
  vec_t                   pos_out_q;
  logic signed [DP_W-1:0] rnd   [3];
  logic signed [P_W-1:0]  p_sum [3];
  comp_t                  p_sat [3];
  logic                   in_box;
  vec_t                   packed_p;

  assign en              = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign cfg_ready_o     = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      gain_q <= '0;
      min_q  <= '0;
      max_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_STEP_SIZE:  step_q <= cfg_data_i[15:0];
        REG_NOISE_GAIN: gain_q <= cfg_data_i[15:0];
        REG_MIN_CORNER: min_q  <= cfg_data_i[VEC_W-1:0];
        REG_MAX_CORNER: max_q  <= cfg_data_i[VEC_W-1:0];
        default: ;
      endcase
    end
  end

  lps_norm #(
    .SIDE_W(SIDE_W)
  ) u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(s_axis_tvalid_i),
    .dir_i  (s_axis_tdata_i[314:252]),
    .side_i ({s_axis_tdata_i[377:315], s_axis_tdata_i[251:0]}),
    .valid_o(n_vld),
    .n_o    (n_c),
    .side_o (n_side)
  );

  assign sd_c = n_side[188:126];
  assign so_c = n_side[251:189];

  always_comb begin
    m_c[0][0] = vec_comp(sd_c, 0);
    m_c[1][1] = vec_comp(sd_c, 1);
    m_c[2][2] = vec_comp(sd_c, 2);
    m_c[0][1] = vec_comp(so_c, 0);
    m_c[1][0] = vec_comp(so_c, 0);
    m_c[1][2] = vec_comp(so_c, 1);
    m_c[2][1] = vec_comp(so_c, 1);
    m_c[0][2] = vec_comp(so_c, 2);
    m_c[2][0] = vec_comp(so_c, 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 5; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= n_vld;
      for (int k = 0; k < 4; k++) vld_q[k+1] <= vld_q[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_q[0] <= n_side[62:0];
      vel_q[0] <= n_side[125:63];
      ent_q[0] <= n_side[314:252];
      for (int k = 0; k < 4; k++) begin
        pos_q[k+1] <= pos_q[k];
        vel_q[k+1] <= vel_q[k];
        ent_q[k+1] <= ent_q[k];
      end
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          pr1_q[i][j] <= PR_W'(m_c[i][j]) * PR_W'(n_c[j]);
        end
        v2_q[i]  <= V_W'(pr1_q[i][0]) + V_W'(pr1_q[i][1]) + V_W'(pr1_q[i][2]);
        vg3_q[i] <= VG_W'(v2_q[i]) * VG_W'($signed({1'b0, gain_q}));
        a4_q[i]  <= A_W'($signed({vec_comp(vel_q[2], i), 11'b0}))
                  + A_W'($signed(vg3_q[i][VG_W-1:16]));
        dp5_q[i] <= DP_W'(a4_q[i]) * DP_W'($signed({1'b0, step_q}));
      end
    end
  end

  // round half up, add to position, clamp, then test the box
  always_comb begin
    in_box = 1'b1;
    for (int i = 0; i < 3; i++) begin
      rnd[i]   = dp5_q[i] + HALF;
      p_sum[i] = P_W'(vec_comp(pos_q[4], i)) + P_W'($signed(rnd[i][DP_W-1:23]));
      if (p_sum[i] < P_MIN) begin
        p_sat[i] = comp_t'(P_MIN);
      end else if (p_sum[i] > P_MAX) begin
        p_sat[i] = comp_t'(P_MAX);
      end else begin
        p_sat[i] = comp_t'(p_sum[i]);
      end
      if (p_sat[i] < vec_comp(min_q, i) || p_sat[i] > vec_comp(max_q, i)) begin
        in_box = 1'b0;
      end
    end
    packed_p = {p_sat[2], p_sat[1], p_sat[0]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= vld_q[4];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pos_out_q <= in_box ? packed_p : ent_q[4];
      reseed_q  <= !in_box;
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {1'b0, pos_out_q};
  assign m_axis_tuser_o  = reseed_q;

  `LPS_ASSERT_IMP(a_kept_x_in_box, out_vld_q && !reseed_q, ($signed(pos_out_q[20:0]) >= $signed(min_q[20:0])) && ($signed(pos_out_q[20:0]) <= $signed(max_q[20:0])), "kept particle outside box on x")
  `LPS_ASSERT_IMP(a_norm_bound, n_vld, (n_c[0] <= 13'sd2050) && (n_c[0] >= -13'sd2050) && (n_c[1] <= 13'sd2050) && (n_c[1] >= -13'sd2050), "normalized component out of range")
  `LPS_ASSERT_NEXT(a_stall_holds_pipe, !en, $stable(vld_q[4]) && $stable(n_vld), "pipeline moved during stall")

endmodule
